// ===== rtl/fwmd_pkg.sv =====
// ----------------------------------------------------------------------------
// fwmd_pkg
// Shared types, constants and helpers of the float word marker deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package fwmd_pkg;

	localparam int WORD_W      = 32;
	localparam int MAX_WORDS   = 64;
	localparam int STORE_DEPTH = 64;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int LEN_W       = 6;
	localparam int TDATA_W     = 40;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [WORD_W-1:0] START_MARK = 32'h4996_B438;
	localparam logic [WORD_W-1:0] END_MARK   = 32'hC996_B438;
	localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(MAX_WORDS - 1);

	typedef enum logic [1:0] {
		KIND_OTHER,
		KIND_START,
		KIND_END
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [WORD_W-1:0] word;
	} q_item_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_READ,
		ST_EMIT
	} back_state_t;

	function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/float_word_marker_deframer.sv =====
// ----------------------------------------------------------------------------
// float_word_marker_deframer
// Cuts messages framed by float marker words out of a stream of 32-bit words.
// ----------------------------------------------------------------------------
// Input stream s_axis carries one received word per transfer. cfg_wr_en with
// cfg_wr_data selects byte reversal of every received word. A start marker
// (1234567.0) while idle opens a message, an end marker (-1234567.0) while a
// message is open closes it, and other words inside a message are stored, up
// to 63 of them; further words overwrite the last slot, which is dropped.
// A closed message leaves on m_axis as one transfer per stored word, tlast on
// the final one, each carrying the message length. Empty messages send none.
// An input word is registered into a two-entry queue and processed from
// there; ordinary words sustain one per cycle outside a readout. Readout
// alternates a read state and an emit state per word, set by the registered
// read port of the word store, and the queue stops accepting input once it
// fills during a readout. Reset clears the message state, the queue and the
// output valid flag; the store needs no clearing. While m_axis_tready is low
// the current result holds in the output register and readout waits.
// ----------------------------------------------------------------------------
`default_nettype none

module float_word_marker_deframer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic                          cfg_wr_data,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [fwmd_pkg::WORD_W-1:0]   s_axis_tdata,  // rx_word
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [fwmd_pkg::TDATA_W-1:0]       m_axis_tdata,  // msg_word, msg_length, pad
	output logic                               m_axis_tlast
);

	fwmd_pkg::q_item_t                q_wr_item;
	fwmd_pkg::q_item_t                q_rd_item;
	logic                             q_push;
	logic                             q_pop;
	logic                             q_full;
	logic                             q_valid;
	logic [fwmd_pkg::WORD_W-1:0]      msg_word;
	logic [fwmd_pkg::LEN_W-1:0]       msg_length;

	fwmd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_wr_item     (q_wr_item)
	);

	fwmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (q_wr_item),
		.pop     (q_pop),
		.full    (q_full),
		.valid   (q_valid),
		.rd_item (q_rd_item)
	);

	fwmd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_rd_item (q_rd_item),
		.q_pop     (q_pop),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_word    (msg_word),
		.m_length  (msg_length),
		.m_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {
		(fwmd_pkg::TDATA_W - fwmd_pkg::WORD_W - fwmd_pkg::LEN_W)'(0),
		msg_length,
		msg_word
	};

endmodule

`default_nettype wire

// ===== rtl/fwmd_front.sv =====
// ----------------------------------------------------------------------------
// fwmd_front
// Input side: byte order correction and marker classification of each word.
// ----------------------------------------------------------------------------
`default_nettype none

module fwmd_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic                         cfg_wr_data,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [fwmd_pkg::WORD_W-1:0]  s_axis_tdata,
	input  wire logic                         q_full,
	output logic                              q_push,
	output fwmd_pkg::q_item_t                 q_wr_item
);

	logic                        reverse_q;
	logic [fwmd_pkg::WORD_W-1:0] word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_q <= 1'b0;
		end else if (cfg_wr_en) begin
			reverse_q <= cfg_wr_data;
		end
	end

	assign word          = reverse_q ? fwmd_pkg::swap_bytes(s_axis_tdata) : s_axis_tdata;
	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	always_comb begin
		q_wr_item.word = word;
		if (word == fwmd_pkg::START_MARK) begin
			q_wr_item.kind = fwmd_pkg::KIND_START;
		end else if (word == fwmd_pkg::END_MARK) begin
			q_wr_item.kind = fwmd_pkg::KIND_END;
		end else begin
			q_wr_item.kind = fwmd_pkg::KIND_OTHER;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fwmd_queue.sv =====
// ----------------------------------------------------------------------------
// fwmd_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fwmd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire fwmd_pkg::q_item_t wr_item,
	input  wire logic              pop,
	output logic                   full,
	output logic                   valid,
	output fwmd_pkg::q_item_t      rd_item
);

	fwmd_pkg::q_item_t             slots_q [fwmd_pkg::QUEUE_DEPTH];
	logic [fwmd_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [fwmd_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [fwmd_pkg::QCNT_W-1:0]   count_q;
	logic                          do_pop;

	assign full    = count_q == fwmd_pkg::QCNT_W'(fwmd_pkg::QUEUE_DEPTH);
	assign valid   = count_q != '0;
	assign rd_item = slots_q[rd_ptr_q];
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fwmd_back.sv =====
// ----------------------------------------------------------------------------
// fwmd_back
// Message state, word store and readout of a completed message.
// ----------------------------------------------------------------------------
`default_nettype none

module fwmd_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire fwmd_pkg::q_item_t             q_rd_item,
	output logic                               q_pop,
	output logic                               m_valid,
	input  wire logic                          m_ready,
	output logic [fwmd_pkg::WORD_W-1:0]        m_word,
	output logic [fwmd_pkg::LEN_W-1:0]         m_length,
	output logic                               m_last
);

	fwmd_pkg::back_state_t         state_q;
	fwmd_pkg::back_state_t         state_nxt;
	logic                          in_msg_q;
	logic [fwmd_pkg::IDX_W-1:0]    widx_q;
	logic [fwmd_pkg::IDX_W-1:0]    rd_idx_q;
	logic [fwmd_pkg::WORD_W-1:0]   store_q [fwmd_pkg::STORE_DEPTH];
	logic [fwmd_pkg::WORD_W-1:0]   rdata_q;
	logic                          out_valid_q;
	logic [fwmd_pkg::WORD_W-1:0]   out_word_q;
	logic [fwmd_pkg::LEN_W-1:0]    out_len_q;
	logic                          out_last_q;
	logic                          is_end;
	logic                          is_start;
	logic                          out_free;
	logic                          rd_last;
	logic                          mem_we;
	logic                          rd_en;
	logic                          load_out;

	assign is_end   = q_rd_item.kind == fwmd_pkg::KIND_END;
	assign is_start = q_rd_item.kind == fwmd_pkg::KIND_START;
	assign out_free = !out_valid_q || m_ready;
	assign rd_last  = rd_idx_q == (widx_q - 1'b1);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			fwmd_pkg::ST_RUN: begin
				if (q_valid && in_msg_q && is_end && widx_q != '0) begin
					state_nxt = fwmd_pkg::ST_READ;
				end
			end
			fwmd_pkg::ST_READ: begin
				state_nxt = fwmd_pkg::ST_EMIT;
			end
			fwmd_pkg::ST_EMIT: begin
				if (out_free) begin
					state_nxt = rd_last ? fwmd_pkg::ST_RUN : fwmd_pkg::ST_READ;
				end
			end
			default: begin
				state_nxt = fwmd_pkg::ST_RUN;
			end
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			fwmd_pkg::ST_RUN: begin
				q_pop = q_valid;
			end
			fwmd_pkg::ST_READ: begin
				rd_en = 1'b1;
			end
			fwmd_pkg::ST_EMIT: begin
				load_out = out_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	assign mem_we = q_pop && in_msg_q && !is_end;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[widx_q] <= q_rd_item.word;
		end
		if (rd_en) begin
			rdata_q <= store_q[rd_idx_q];
		end
		if (load_out) begin
			out_word_q <= rdata_q;
			out_len_q  <= fwmd_pkg::LEN_W'(widx_q);
			out_last_q <= rd_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fwmd_pkg::ST_RUN;
			in_msg_q    <= 1'b0;
			widx_q      <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (q_pop) begin
				if (in_msg_q) begin
					if (is_end) begin
						in_msg_q <= 1'b0;
						rd_idx_q <= '0;
					end else if (widx_q < fwmd_pkg::LAST_IDX) begin
						widx_q <= widx_q + 1'b1;
					end
				end else if (is_start) begin
					in_msg_q <= 1'b1;
					widx_q   <= '0;
				end
			end
			if (load_out && !rd_last) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_valid  = out_valid_q;
	assign m_word   = out_word_q;
	assign m_length = out_len_q;
	assign m_last   = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/fwmd_checker.sv =====
// ----------------------------------------------------------------------------
// fwmd_checker
// Port-level checks of the float word marker deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fwmd_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [fwmd_pkg::TDATA_W-1:0]  m_axis_tdata,
	input wire logic                          m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[37:32] != '0)
		else $error("result with zero message length");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:38] == '0)
		else $error("nonzero pad bits in result");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

endmodule

bind float_word_marker_deframer fwmd_checker u_fwmd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
